[design/bhu_pkg.sv]
// Shared constants, codes, address function and weight function of the B-spline height upsampler.
// Depends on nothing; used by bspline_height_upsampler.
package bhu_pkg;

	// Grid geometry
	localparam int BASE_POINTS   = 16;
	localparam int UPSAMPLE_RATE = 4;   // power of two: fine coordinates split by bit fields
	localparam int HEIGHT_BITS   = 16;

	// Port field widths
	localparam int OP_BITS     = 2;
	localparam int COORD_BITS  = 5;
	localparam int SAMPLE_BITS = 16;
	localparam int FINE_BITS   = 7;
	localparam int OUT_BITS    = 24;

	localparam int SIDE      = BASE_POINTS + 3;
	localparam int MEM_DEPTH = SIDE * SIDE;
	localparam int ADDR_BITS = $clog2(MEM_DEPTH);
	localparam int FINE_LAST = BASE_POINTS * UPSAMPLE_RATE;
	localparam int FRAC_BITS = $clog2(UPSAMPLE_RATE);
	localparam int TAP_BITS  = 4;       // 4x4 spline footprint

	// Weights: one axis up to 4*R^3, 2D product, full sum (6*R^3)^2
	localparam int W_BITS    = $clog2(4 * UPSAMPLE_RATE ** 3 + 1);
	localparam int W2_BITS   = 2 * W_BITS;
	localparam int SUMW_BITS = $clog2(36 * UPSAMPLE_RATE ** 6 + 1);
	localparam int ACC_BITS  = HEIGHT_BITS + SUMW_BITS;
	localparam int MUL_BITS  = W2_BITS + HEIGHT_BITS + 1;

	// Spline scaling: Q.8 of acc / (36*R^6) is floor((acc + DIV/2) / DIV), DIV = 9 << DIV_SH
	localparam int DIV     = 36 * UPSAMPLE_RATE ** 6 / 256;
	localparam int DIV_SH  = 6 * FRAC_BITS - 6;
	localparam int DIV_ODD = DIV >> DIV_SH;
	localparam int RND     = DIV / 2;
	localparam int LIN_SH  = 8 - FRAC_BITS;

	// Divide by the odd factor: offset to a positive value, multiply by a reciprocal
	localparam int    T_BITS     = ACC_BITS - DIV_SH;
	localparam int    NB         = T_BITS + 1;
	localparam longint K_Q       = longint'(1) << (T_BITS - 4);
	localparam longint K_OFF     = DIV_ODD * K_Q;
	localparam int    RECIP_SH   = NB + 4;
	localparam longint RECIP     = ((longint'(1) << RECIP_SH) + DIV_ODD - 1) / DIV_ODD;
	localparam int    RECIP_BITS = RECIP_SH - 3;
	localparam int    PR_BITS    = NB + RECIP_BITS;
	localparam int    RES_BITS   = ACC_BITS + 8;

	localparam int OUT_MAX = 2 ** (OUT_BITS - 1) - 1;
	localparam int OUT_MIN = -(2 ** (OUT_BITS - 1));

	// Operation codes
	localparam logic [OP_BITS-1:0] OP_NEW_TILE = 2'd0;
	localparam logic [OP_BITS-1:0] OP_LOAD     = 2'd1;
	localparam logic [OP_BITS-1:0] OP_QUERY    = 2'd2;

	// Query modes
	localparam logic [1:0] MODE_SPLINE = 2'd0;
	localparam logic [1:0] MODE_LINX   = 2'd1;
	localparam logic [1:0] MODE_LINY   = 2'd2;
	localparam logic [1:0] MODE_ZERO   = 2'd3;

	function automatic logic [ADDR_BITS-1:0] addr_of(input logic [COORD_BITS-1:0] row,
		input logic [COORD_BITS-1:0] col);
		return ADDR_BITS'(int'(row) * SIDE + int'(col));
	endfunction

	// Cubic B-spline weight of tap k at fraction f/R, scaled by 6*R^3
	function automatic logic [W_BITS-1:0] bweight(input logic [1:0] k,
		input logic [FRAC_BITS-1:0] f);
		int x;
		int r;
		int w;
		x = int'(f);
		r = UPSAMPLE_RATE;
		case (k)
			2'd0: w = (r - x) * (r - x) * (r - x);
			2'd1: w = 3 * x * x * x - 6 * x * x * r + 4 * r * r * r;
			2'd2: w = -3 * x * x * x + 3 * x * x * r + 3 * x * r * r + r * r * r;
			default: w = x * x * x;
		endcase
		return W_BITS'(w);
	endfunction

endpackage

[design/bspline_height_upsampler.sv]
// Top level of the cubic B-spline height upsampler: base-sample memory, tap sequencer,
// multiply-accumulate pipeline, reciprocal scaling and output register.
// Depends on bhu_pkg.
//
// Usage
//  One input channel (item_valid / item_stall) carries an op and its fields; one output
//  channel (result_valid / result_stall) returns fine_height for each query item.
//  New tile and load items finish at acceptance: a load writes the base-sample memory at the
//  accepting edge, and a new tile clears the positive-sample flag.
//  A query reads its taps one per cycle through the single read port of the base-sample
//  memory into one multiply-accumulate, then scales the sum.
//  Interior query: 16 taps through the accumulate pipeline, then the scaling steps.
//  Top/bottom row or left/right column query: 1 or 2 taps.
//  Query that returns zero (no positive sample, off grid): goes straight to the final state.
//  Items are taken one at a time; item_stall is high while a query is in flight.
//  A finished result waits in the output register while result_stall is high; the block
//  still takes loads and the next query meanwhile, and holds a further result until the
//  register frees.
//  Reset clears the sequencer, the output valid and the positive-sample flag. The memory
//  is not cleared: every base sample that a query touches must be loaded first.
module bspline_height_upsampler (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    item_valid,
	output logic                                    item_stall,
	input  logic [bhu_pkg::OP_BITS-1:0]             op,
	input  logic [bhu_pkg::COORD_BITS-1:0]          base_col,
	input  logic [bhu_pkg::COORD_BITS-1:0]          base_row,
	input  logic signed [bhu_pkg::SAMPLE_BITS-1:0]  height_sample,
	input  logic [bhu_pkg::FINE_BITS-1:0]           fine_col,
	input  logic [bhu_pkg::FINE_BITS-1:0]           fine_row,
	output logic                                    result_valid,
	input  logic                                    result_stall,
	output logic signed [bhu_pkg::OUT_BITS-1:0]     fine_height
);

	// Sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	localparam logic [bhu_pkg::FINE_BITS-1:0] FINE_LAST_V =
		bhu_pkg::FINE_BITS'(bhu_pkg::FINE_LAST);
	localparam logic [bhu_pkg::RECIP_BITS-1:0] RECIP_W = bhu_pkg::RECIP_BITS'(bhu_pkg::RECIP);

	// Control state
	logic [2:0]                      state_q;
	logic                            any_pos_q;
	logic                            result_valid_q;
	logic [bhu_pkg::TAP_BITS-1:0]    tap_q;
	logic                            v_s1;
	logic                            v_s2;

	// Query context
	logic [1:0]                        mode_q;
	logic [bhu_pkg::TAP_BITS-1:0]      last_q;
	logic [bhu_pkg::COORD_BITS-1:0]    bx_q;
	logic [bhu_pkg::COORD_BITS-1:0]    by_q;
	logic [bhu_pkg::FRAC_BITS-1:0]     u_q;
	logic [bhu_pkg::FRAC_BITS-1:0]     v_q;

	// Datapath
	logic signed [bhu_pkg::HEIGHT_BITS-1:0] mem [bhu_pkg::MEM_DEPTH];
	logic signed [bhu_pkg::HEIGHT_BITS-1:0] rd_s1;
	logic [bhu_pkg::W2_BITS-1:0]            w_s1;
	logic signed [bhu_pkg::MUL_BITS-1:0]    mul;
	logic signed [bhu_pkg::MUL_BITS-1:0]    prod_s2;
	logic signed [bhu_pkg::ACC_BITS-1:0]    acc_q;
	logic signed [bhu_pkg::ACC_BITS-1:0]    acc_rnd;
	logic signed [bhu_pkg::ACC_BITS-1:0]    t_full;
	logic [bhu_pkg::NB-1:0]                 n_next;
	logic [bhu_pkg::NB-1:0]                 n_q;
	logic [bhu_pkg::PR_BITS-1:0]            recip_q;
	logic signed [bhu_pkg::RES_BITS-1:0]    spl_res;
	logic signed [bhu_pkg::RES_BITS-1:0]    lin_res;
	logic signed [bhu_pkg::RES_BITS-1:0]    res;
	logic signed [bhu_pkg::OUT_BITS-1:0]    res_sat;
	logic signed [bhu_pkg::OUT_BITS-1:0]    result_q;

	// Input side
	logic                                   item_acc;
	logic                                   load_ok;
	logic                                   mem_we;
	logic signed [bhu_pkg::HEIGHT_BITS-1:0] h_load;
	logic [bhu_pkg::ADDR_BITS-1:0]          waddr;

	// Query decode
	logic [bhu_pkg::FINE_BITS-1:0]     c_sat;
	logic [bhu_pkg::FINE_BITS-1:0]     r_sat;
	logic [bhu_pkg::FRAC_BITS-1:0]     q_u;
	logic [bhu_pkg::FRAC_BITS-1:0]     q_v;
	logic [bhu_pkg::COORD_BITS-1:0]    q_bx;
	logic [bhu_pkg::COORD_BITS-1:0]    q_by;
	logic [1:0]                        q_mode;
	logic [bhu_pkg::TAP_BITS-1:0]      q_last;

	// Tap generation
	logic [1:0]                        jx;
	logic [1:0]                        jy;
	logic [bhu_pkg::COORD_BITS-1:0]    t_col;
	logic [bhu_pkg::COORD_BITS-1:0]    t_row;
	logic [bhu_pkg::W2_BITS-1:0]       t_w;
	logic [bhu_pkg::ADDR_BITS-1:0]     raddr;

	// One item at a time: take a new one only with the sequencer idle
	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;

	// Load path: sign extend or wrap the sample to the stored width
	assign h_load  = bhu_pkg::HEIGHT_BITS'(32'(height_sample));
	assign load_ok = (base_col < bhu_pkg::COORD_BITS'(bhu_pkg::SIDE)) &&
		(base_row < bhu_pkg::COORD_BITS'(bhu_pkg::SIDE));
	assign mem_we  = item_acc && (op == bhu_pkg::OP_LOAD) && load_ok;
	assign waddr   = bhu_pkg::addr_of(base_row, base_col);

	// Query decode: saturate the fine point, split into base cell and fraction
	always_comb begin
		c_sat = (fine_col > FINE_LAST_V) ? FINE_LAST_V : fine_col;
		r_sat = (fine_row > FINE_LAST_V) ? FINE_LAST_V : fine_row;
		q_u   = c_sat[bhu_pkg::FRAC_BITS-1:0];
		q_v   = r_sat[bhu_pkg::FRAC_BITS-1:0];
		q_bx  = bhu_pkg::COORD_BITS'(c_sat >> bhu_pkg::FRAC_BITS) + bhu_pkg::COORD_BITS'(1);
		q_by  = bhu_pkg::COORD_BITS'(r_sat >> bhu_pkg::FRAC_BITS) + bhu_pkg::COORD_BITS'(1);
		if (!any_pos_q) begin
			// flat tile: only on-grid points carry their sample
			q_mode = (q_u == '0 && q_v == '0) ? bhu_pkg::MODE_LINX : bhu_pkg::MODE_ZERO;
			q_last = '0;
		end else if (r_sat inside {bhu_pkg::FINE_BITS'(0), FINE_LAST_V}) begin
			q_mode = bhu_pkg::MODE_LINX;
			q_last = (q_u == '0) ? '0 : bhu_pkg::TAP_BITS'(1);
		end else if (c_sat inside {bhu_pkg::FINE_BITS'(0), FINE_LAST_V}) begin
			q_mode = bhu_pkg::MODE_LINY;
			q_last = (q_v == '0) ? '0 : bhu_pkg::TAP_BITS'(1);
		end else begin
			q_mode = bhu_pkg::MODE_SPLINE;
			q_last = '1;
		end
	end

	// Tap address and weight for the current tap
	assign jx = tap_q[1:0];
	assign jy = tap_q[3:2];

	always_comb begin
		t_col = bx_q;
		t_row = by_q;
		t_w   = '0;
		case (mode_q)
			bhu_pkg::MODE_SPLINE: begin
				t_col = bx_q + bhu_pkg::COORD_BITS'(jx) - bhu_pkg::COORD_BITS'(1);
				t_row = by_q + bhu_pkg::COORD_BITS'(jy) - bhu_pkg::COORD_BITS'(1);
				t_w   = bhu_pkg::W2_BITS'(bhu_pkg::bweight(jx, u_q)) *
					bhu_pkg::W2_BITS'(bhu_pkg::bweight(jy, v_q));
			end
			bhu_pkg::MODE_LINX: begin
				t_col = bx_q + bhu_pkg::COORD_BITS'(tap_q[0]);
				t_w   = tap_q[0] ? bhu_pkg::W2_BITS'(u_q) :
					bhu_pkg::W2_BITS'(bhu_pkg::UPSAMPLE_RATE) - bhu_pkg::W2_BITS'(u_q);
			end
			bhu_pkg::MODE_LINY: begin
				t_row = by_q + bhu_pkg::COORD_BITS'(tap_q[0]);
				t_w   = tap_q[0] ? bhu_pkg::W2_BITS'(v_q) :
					bhu_pkg::W2_BITS'(bhu_pkg::UPSAMPLE_RATE) - bhu_pkg::W2_BITS'(v_q);
			end
			default: ;
		endcase
		raddr = bhu_pkg::addr_of(t_row, t_col);
	end

	// Base-sample memory: one write port for loads, one registered read port for taps
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= h_load;
		end
		rd_s1 <= mem[raddr];
	end

	assign mul = bhu_pkg::MUL_BITS'($signed({1'b0, w_s1})) * bhu_pkg::MUL_BITS'(rd_s1);

	// Scaling: round, shift out the power of two, offset, then the odd-factor reciprocal
	assign acc_rnd = acc_q + bhu_pkg::ACC_BITS'(bhu_pkg::RND);
	assign t_full  = acc_rnd >>> bhu_pkg::DIV_SH;
	assign n_next  = bhu_pkg::NB'(t_full) + bhu_pkg::NB'(bhu_pkg::K_OFF);

	assign spl_res = $signed(bhu_pkg::RES_BITS'({1'b0, recip_q[bhu_pkg::PR_BITS-1:bhu_pkg::RECIP_SH]}))
		- $signed(bhu_pkg::RES_BITS'(bhu_pkg::K_Q));
	assign lin_res = $signed(bhu_pkg::RES_BITS'(acc_q)) <<< bhu_pkg::LIN_SH;

	always_comb begin
		case (mode_q)
			bhu_pkg::MODE_SPLINE:                  res = spl_res;
			bhu_pkg::MODE_LINX, bhu_pkg::MODE_LINY: res = lin_res;
			default:                               res = '0;
		endcase
		if (res > $signed(bhu_pkg::RES_BITS'(bhu_pkg::OUT_MAX))) begin
			res_sat = bhu_pkg::OUT_BITS'(bhu_pkg::OUT_MAX);
		end else if (res < $signed(bhu_pkg::RES_BITS'(bhu_pkg::OUT_MIN))) begin
			res_sat = bhu_pkg::OUT_BITS'(bhu_pkg::OUT_MIN);
		end else begin
			res_sat = bhu_pkg::OUT_BITS'(res);
		end
	end

	// Sequencer and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			any_pos_q      <= 1'b0;
			result_valid_q <= 1'b0;
			tap_q          <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_RUN);
			v_s2 <= v_s1;
			// raise the result out of the final state once the register frees,
			// drop it once taken
			if (state_q == ST_FIN && (!result_valid_q || !result_stall)) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					tap_q <= '0;
					if (item_acc) begin
						case (op)
							bhu_pkg::OP_NEW_TILE: any_pos_q <= 1'b0;
							bhu_pkg::OP_LOAD: begin
								if (load_ok && !h_load[bhu_pkg::HEIGHT_BITS-1] && h_load != '0) begin
									any_pos_q <= 1'b1;
								end
							end
							bhu_pkg::OP_QUERY: begin
								state_q <= (q_mode == bhu_pkg::MODE_ZERO) ? ST_FIN : ST_RUN;
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					// advance one tap per cycle through the read port
					tap_q <= tap_q + bhu_pkg::TAP_BITS'(1);
					if (tap_q == last_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// hold until the last product is in the accumulator
					if (!v_s1 && !v_s2) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_FIN;
				ST_FIN: begin
					if (!result_valid_q || !result_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Query context, accumulate pipeline and output payload
	always_ff @(posedge clk) begin
		if (item_acc && op == bhu_pkg::OP_QUERY) begin
			mode_q <= q_mode;
			last_q <= q_last;
			bx_q   <= q_bx;
			by_q   <= q_by;
			u_q    <= q_u;
			v_q    <= q_v;
			acc_q  <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + bhu_pkg::ACC_BITS'(prod_s2);
		end
		w_s1    <= t_w;
		prod_s2 <= mul;
		n_q     <= n_next;
		recip_q <= bhu_pkg::PR_BITS'(n_q) * bhu_pkg::PR_BITS'(RECIP_W);
		if (state_q == ST_FIN && (!result_valid_q || !result_stall)) begin
			result_q <= res_sat;
		end
	end

	assign result_valid = result_valid_q;
	assign fine_height  = result_q;

	// A result only appears out of the final state
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside the final state");

	// The tap counter never runs past the query's last tap
	a_tap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (tap_q <= last_q))
		else $error("tap index beyond last tap");

	// Scaling starts only with the accumulate pipeline empty
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCALE) |-> (!v_s1 && !v_s2))
		else $error("scaling started with products in flight");

endmodule
